>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL. Each macro checks on the rising edge of
// clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(lbl, prop)
`define ASSERT_NEVER(lbl, prop)
`endif
`endif

>>> hdl/pvu_pkg.sv
package pvu_pkg;

  localparam int CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgCogGain   = 3'd0,
    CfgSocGain   = 3'd1,
    CfgPosLow    = 3'd2,
    CfgPosHigh   = 3'd3,
    CfgClampMode = 3'd4
  } cfg_idx_e;

  // Reset gain is 1.496 in thousandths; reset bounds are plus and minus 20.
  localparam longint GainMilli = 1496;
  localparam longint BoundInt  = 20;

endpackage

>>> hdl/particle_velocity_position_update_unit.sv
// Particle swarm velocity and position update, one dimension of one particle
// per item.
//
// An item is taken at a rising edge where start_i is high and busy_o is low.
// busy_o stays low, so an item may be started in every cycle. Each result
// appears on new_velocity_o, new_position_o and bound_hit_o for exactly one
// cycle, marked by done_o. Results leave in the order the items came in.
// Throughput is one item per cycle. Most of the pipeline is the periodic
// wrap, whose remainder is found by a restoring divider with one stage per
// bit of the word, behind five stages for the gains, the three products,
// the sum with saturation, the position sum and the bound checks.
//
// Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i, and must
// only change while no item is in flight. Reset empties the pipeline and
// loads gains of 1.496, bounds of plus and minus 20 and clamp mode. The
// receiver cannot hold results off, so nothing in the pipeline ever stalls.
`include "assert_macros.svh"

module particle_velocity_position_update_unit #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_we_i,
  input  logic [pvu_pkg::CfgIdxBits-1:0]               cfg_idx_i,
  input  logic [((WORD_BITS > FRAC_BITS+2) ? WORD_BITS : FRAC_BITS+2)-1:0] cfg_data_i,
  input  logic                                         start_i,
  output logic                                         busy_o,
  input  logic signed [WORD_BITS-1:0]                  velocity_i,
  input  logic signed [WORD_BITS-1:0]                  position_i,
  input  logic signed [WORD_BITS-1:0]                  personal_best_i,
  input  logic signed [WORD_BITS-1:0]                  neighbour_best_i,
  input  logic [FRAC_BITS:0]                           inertia_i,
  input  logic [FRAC_BITS-1:0]                         rand_one_i,
  input  logic [FRAC_BITS-1:0]                         rand_two_i,
  output logic                                         done_o,
  output logic signed [WORD_BITS-1:0]                  new_velocity_o,
  output logic signed [WORD_BITS-1:0]                  new_position_o,
  output logic                                         bound_hit_o
);

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int Latency = WORD_BITS + 6;

  localparam logic [F+1:0] GainRst =
    (F+2)'((pvu_pkg::GainMilli * (longint'(1) << FRAC_BITS) + 500) / 1000);
  localparam logic signed [W-1:0] PosHighRst =
    W'(pvu_pkg::BoundInt * (longint'(1) << FRAC_BITS));
  localparam logic signed [W-1:0] PosLowRst = -PosHighRst;
  localparam logic signed [W-1:0] WordMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WordMin = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W+5:0] SumMax = (W+6)'(WordMax);
  localparam logic signed [W+5:0] SumMin = (W+6)'(WordMin);

  // Configuration registers.
  logic [F+1:0]          cog_q, soc_q;
  logic signed [W-1:0]   lo_q, hi_q;
  logic                  clamp_q;
  logic signed [W:0]     range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cog_q   <= GainRst;
      soc_q   <= GainRst;
      lo_q    <= PosLowRst;
      hi_q    <= PosHighRst;
      clamp_q <= 1'b1;
      range_q <= (W+1)'(PosHighRst) - (W+1)'(PosLowRst);
    end else begin
      range_q <= {hi_q[W-1], hi_q} - {lo_q[W-1], lo_q};
      if (cfg_we_i) begin
        unique case (pvu_pkg::cfg_idx_e'(cfg_idx_i))
          pvu_pkg::CfgCogGain:   cog_q   <= cfg_data_i[F+1:0];
          pvu_pkg::CfgSocGain:   soc_q   <= cfg_data_i[F+1:0];
          pvu_pkg::CfgPosLow:    lo_q    <= cfg_data_i[W-1:0];
          pvu_pkg::CfgPosHigh:   hi_q    <= cfg_data_i[W-1:0];
          pvu_pkg::CfgClampMode: clamp_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  logic wrap_en;
  assign wrap_en = !clamp_q && !range_q[W] && (range_q != '0);

  assign busy_o = 1'b0;

  logic in_acc;
  assign in_acc = start_i && !busy_o;

  // Stage 1: random gains and distances to the best positions.
  logic                  s1_vld_q;
  logic signed [W-1:0]   s1_vel_q, s1_pos_q;
  logic [F:0]            s1_w_q;
  logic [F+1:0]          s1_rho1_q, s1_rho2_q;
  logic signed [W:0]     s1_dif1_q, s1_dif2_q;
  logic [2*F+1:0]        rho1_prod, rho2_prod;

  assign rho1_prod = (2*F+2)'(cog_q) * (2*F+2)'(rand_one_i);
  assign rho2_prod = (2*F+2)'(soc_q) * (2*F+2)'(rand_two_i);

  always_ff @(posedge clk_i) begin
    s1_vel_q  <= velocity_i;
    s1_pos_q  <= position_i;
    s1_w_q    <= inertia_i;
    s1_rho1_q <= rho1_prod[2*F+1:F];
    s1_rho2_q <= rho2_prod[2*F+1:F];
    s1_dif1_q <= {personal_best_i[W-1], personal_best_i} - {position_i[W-1], position_i};
    s1_dif2_q <= {neighbour_best_i[W-1], neighbour_best_i} - {position_i[W-1], position_i};
  end

  // Stage 2: the three products, floored to the fraction.
  logic                  s2_vld_q;
  logic signed [W-1:0]   s2_pos_q;
  logic signed [W+3:0]   s2_t0_q, s2_t1_q, s2_t2_q;
  logic signed [W+F+1:0] p0;
  logic signed [W+F+3:0] p1, p2;

  assign p0 = (W+F+2)'($signed({1'b0, s1_w_q})) * (W+F+2)'(s1_vel_q);
  assign p1 = (W+F+4)'($signed({1'b0, s1_rho1_q})) * (W+F+4)'(s1_dif1_q);
  assign p2 = (W+F+4)'($signed({1'b0, s1_rho2_q})) * (W+F+4)'(s1_dif2_q);

  always_ff @(posedge clk_i) begin
    s2_pos_q <= s1_pos_q;
    s2_t0_q  <= (W+4)'(p0 >>> F);
    s2_t1_q  <= (W+4)'(p1 >>> F);
    s2_t2_q  <= (W+4)'(p2 >>> F);
  end

  // Stage 3: velocity sum with saturation.
  logic                  s3_vld_q;
  logic signed [W-1:0]   s3_pos_q, s3_nv_q;
  logic signed [W+5:0]   vsum;
  logic signed [W-1:0]   nv_d;

  always_comb begin
    vsum = (W+6)'(s2_t0_q) + (W+6)'(s2_t1_q) + (W+6)'(s2_t2_q);
    if (vsum > SumMax) begin
      nv_d = WordMax;
    end else if (vsum < SumMin) begin
      nv_d = WordMin;
    end else begin
      nv_d = vsum[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    s3_pos_q <= s2_pos_q;
    s3_nv_q  <= nv_d;
  end

  // Stage 4: position sum with saturation.
  logic                  s4_vld_q;
  logic signed [W-1:0]   s4_nv_q, s4_np_q;
  logic signed [W:0]     psum;
  logic signed [W-1:0]   np_d;

  always_comb begin
    psum = {s3_pos_q[W-1], s3_pos_q} + {s3_nv_q[W-1], s3_nv_q};
    if (psum[W] != psum[W-1]) begin
      np_d = psum[W] ? WordMin : WordMax;
    end else begin
      np_d = psum[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    s4_nv_q <= s3_nv_q;
    s4_np_q <= np_d;
  end

  // Bound checks feed entry 0 of the remainder pipeline; entries 1 to W
  // each resolve one bit of the distance past the bound modulo the range.
  logic                  dv_vld_q   [W+1];
  logic                  dv_hit_q   [W+1];
  logic                  dv_wrap_q  [W+1];
  logic                  dv_below_q [W+1];
  logic signed [W-1:0]   dv_nv_q    [W+1];
  logic signed [W-1:0]   dv_np_q    [W+1];
  logic [W-1:0]          dv_rem_q   [W+1];
  logic [W-1:0]          dv_dvd_q   [W+1];
  logic [W-1:0]          divisor_q;

  logic                  below, above, hit;
  logic [W-1:0]          dist_lo, dist_hi;

  assign below   = s4_np_q < lo_q;
  assign above   = s4_np_q > hi_q;
  assign hit     = below || above;
  assign dist_lo = W'(lo_q - s4_np_q);
  assign dist_hi = W'(s4_np_q - hi_q);

  always_ff @(posedge clk_i) begin
    divisor_q     <= range_q[W-1:0];
    dv_hit_q[0]   <= hit;
    dv_wrap_q[0]  <= hit && wrap_en;
    dv_below_q[0] <= below;
    dv_nv_q[0]    <= s4_nv_q;
    dv_np_q[0]    <= !hit ? s4_np_q : (below ? lo_q : hi_q);
    dv_rem_q[0]   <= '0;
    dv_dvd_q[0]   <= below ? dist_lo : dist_hi;
  end

  for (genvar k = 1; k <= W; k++) begin : g_div
    logic [W:0] shf;
    logic       ge;

    assign shf = {dv_rem_q[k-1], dv_dvd_q[k-1][W-1]};
    assign ge  = shf >= {1'b0, divisor_q};

    always_ff @(posedge clk_i) begin
      dv_hit_q[k]   <= dv_hit_q[k-1];
      dv_wrap_q[k]  <= dv_wrap_q[k-1];
      dv_below_q[k] <= dv_below_q[k-1];
      dv_nv_q[k]    <= dv_nv_q[k-1];
      dv_np_q[k]    <= dv_np_q[k-1];
      dv_rem_q[k]   <= ge ? W'(shf - {1'b0, divisor_q}) : shf[W-1:0];
      dv_dvd_q[k]   <= {dv_dvd_q[k-1][W-2:0], 1'b0};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else begin
        dv_vld_q[k] <= dv_vld_q[k-1];
      end
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      dv_vld_q[0] <= 1'b0;
      done_o      <= 1'b0;
    end else begin
      s1_vld_q    <= in_acc;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      s4_vld_q    <= s3_vld_q;
      dv_vld_q[0] <= s4_vld_q;
      done_o      <= dv_vld_q[W];
    end
  end

  // Output stage: apply the wrap and zero the velocity after a correction.
  logic signed [W-1:0] wrapped;
  assign wrapped = dv_below_q[W] ? W'(hi_q - $signed(dv_rem_q[W]))
                                 : W'(lo_q + $signed(dv_rem_q[W]));

  always_ff @(posedge clk_i) begin
    new_velocity_o <= dv_hit_q[W] ? '0 : dv_nv_q[W];
    new_position_o <= dv_wrap_q[W] ? wrapped : dv_np_q[W];
    bound_hit_o    <= dv_hit_q[W];
  end

  `ASSERT_AT(a_latency, in_acc |-> ##(Latency) done_o)
  `ASSERT_AT(a_div_to_out, dv_vld_q[W] |=> done_o)
  `ASSERT_NEVER(a_hit_keeps_velocity, done_o && bound_hit_o && (new_velocity_o != '0))

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

typedef struct {
  logic signed [31:0] velocity;
  logic signed [31:0] position;
  logic signed [31:0] personal_best;
  logic signed [31:0] neighbour_best;
  logic [16:0]        inertia;
  logic [15:0]        rand_one;
  logic [15:0]        rand_two;
} pvu_item_t;

typedef struct {
  logic signed [31:0] velocity;
  logic signed [31:0] position;
  logic               hit;
} pvu_update_t;

class pvu_scoreboard;
  bit [17:0]   cog_gain;
  bit [17:0]   soc_gain;
  longint      pos_low;
  longint      pos_high;
  bit          clamp_mode;
  pvu_update_t expected_updates[$];
  int unsigned checked;
  int unsigned corrected;
  int unsigned wrapped;
  int unsigned mismatches;

  function new();
    cog_gain   = 18'((pvu_pkg::GainMilli * 65536 + 500) / 1000);
    soc_gain   = cog_gain;
    pos_low    = -pvu_pkg::BoundInt * 65536;
    pos_high   = pvu_pkg::BoundInt * 65536;
    clamp_mode = 1'b1;
  endfunction

  static function longint sat_word(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  static function longint floor_scale(longint coef, longint x);
    return (coef * x) >>> 16;
  endfunction

  function void set_reg(pvu_pkg::cfg_idx_e idx, logic [31:0] data);
    case (idx)
      pvu_pkg::CfgCogGain:   cog_gain = data[17:0];
      pvu_pkg::CfgSocGain:   soc_gain = data[17:0];
      pvu_pkg::CfgPosLow:    pos_low = longint'($signed(data));
      pvu_pkg::CfgPosHigh:   pos_high = longint'($signed(data));
      pvu_pkg::CfgClampMode: clamp_mode = data[0];
      default: ;
    endcase
  endfunction

  function void note_item(pvu_item_t it);
    longint      rho1;
    longint      rho2;
    longint      vel;
    longint      pos;
    longint      x;
    longint      extent;
    bit          hit;
    bit          wrap;
    pvu_update_t upd;
    x = longint'(it.position);
    rho1 = (longint'(cog_gain) * longint'(it.rand_one)) >>> 16;
    rho2 = (longint'(soc_gain) * longint'(it.rand_two)) >>> 16;
    vel = sat_word(floor_scale(longint'(it.inertia), longint'(it.velocity))
                   + floor_scale(rho1, longint'(it.personal_best) - x)
                   + floor_scale(rho2, longint'(it.neighbour_best) - x));
    pos = sat_word(x + vel);
    extent = pos_high - pos_low;
    hit = 1'b0;
    wrap = 1'b0;
    if (pos < pos_low) begin
      hit = 1'b1;
      if (!clamp_mode && extent > 0) begin
        pos = pos_high - ((pos_low - pos) % extent);
        wrap = 1'b1;
      end else begin
        pos = pos_low;
      end
    end else if (pos > pos_high) begin
      hit = 1'b1;
      if (!clamp_mode && extent > 0) begin
        pos = pos_low + ((pos - pos_high) % extent);
        wrap = 1'b1;
      end else begin
        pos = pos_high;
      end
    end
    if (hit) vel = 0;
    upd.velocity = vel[31:0];
    upd.position = pos[31:0];
    upd.hit = hit;
    expected_updates.push_back(upd);
    corrected += hit;
    wrapped += wrap;
  endfunction

  function void check_result(logic signed [31:0] vel, logic signed [31:0] pos, logic hit);
    pvu_update_t want;
    if (expected_updates.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected result: velocity %0d position %0d bound_hit %0b", vel, pos, hit);
      return;
    end
    want = expected_updates.pop_front();
    checked++;
    if (vel !== want.velocity || pos !== want.position || hit !== want.hit) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on result %0d: velocity %0d/%0d position %0d/%0d hit %0b/%0b %s",
                 checked, want.velocity, vel, want.position, pos, want.hit, hit,
                 "(expected/actual)");
    end
  endfunction
endclass

module tb;

  localparam int          LATENCY     = 38;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam longint      Q           = 65536;
  localparam longint      WMAX        = 64'sd2147483647;
  localparam longint      WMIN        = -64'sd2147483648;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [pvu_pkg::CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [31:0]                   cfg_data_i = '0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  logic signed [31:0]            velocity_i = '0;
  logic signed [31:0]            position_i = '0;
  logic signed [31:0]            personal_best_i = '0;
  logic signed [31:0]            neighbour_best_i = '0;
  logic [16:0]                   inertia_i = '0;
  logic [15:0]                   rand_one_i = '0;
  logic [15:0]                   rand_two_i = '0;
  logic                          done_o;
  logic signed [31:0]            new_velocity_o;
  logic signed [31:0]            new_position_o;
  logic                          bound_hit_o;

  pvu_scoreboard board;
  int unsigned   cycles = 0;
  int unsigned   settings_used = 0;

  particle_velocity_position_update_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .velocity_i       (velocity_i),
    .position_i       (position_i),
    .personal_best_i  (personal_best_i),
    .neighbour_best_i (neighbour_best_i),
    .inertia_i        (inertia_i),
    .rand_one_i       (rand_one_i),
    .rand_two_i       (rand_two_i),
    .done_o           (done_o),
    .new_velocity_o   (new_velocity_o),
    .new_position_o   (new_position_o),
    .bound_hit_o      (bound_hit_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               board.expected_updates.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic pvu_item_t make_item(longint v, longint x, longint pb, longint nb,
                                          longint w, longint r1, longint r2);
    pvu_item_t it;
    it.velocity = v[31:0];
    it.position = x[31:0];
    it.personal_best = pb[31:0];
    it.neighbour_best = nb[31:0];
    it.inertia = w[16:0];
    it.rand_one = r1[15:0];
    it.rand_two = r2[15:0];
    return it;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o)
      board.note_item(make_item(velocity_i, position_i, personal_best_i, neighbour_best_i,
                                inertia_i, rand_one_i, rand_two_i));
    if (rst_ni && done_o)
      board.check_result(new_velocity_o, new_position_o, bound_hit_o);
  end

  task automatic send_item(pvu_item_t it, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    start_i          <= 1'b1;
    velocity_i       <= it.velocity;
    position_i       <= it.position;
    personal_best_i  <= it.personal_best;
    neighbour_best_i <= it.neighbour_best;
    inertia_i        <= it.inertia;
    rand_one_i       <= it.rand_one;
    rand_two_i       <= it.rand_two;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic directed(longint v, longint x, longint pb, longint nb,
                          longint w, longint r1, longint r2);
    send_item(make_item(v, x, pb, nb, w, r1, r2), 1'b1);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (board.expected_updates.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(pvu_pkg::cfg_idx_e idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.set_reg(idx, data);
  endtask

  task automatic apply_setting(longint cog, longint soc, longint lo, longint hi, bit clamp);
    logic [31:0] noise;
    noise = $urandom;
    write_reg(pvu_pkg::CfgCogGain, {noise[31:18], cog[17:0]});
    noise = $urandom;
    write_reg(pvu_pkg::CfgSocGain, {noise[31:18], soc[17:0]});
    write_reg(pvu_pkg::CfgPosLow, lo[31:0]);
    write_reg(pvu_pkg::CfgPosHigh, hi[31:0]);
    noise = $urandom;
    write_reg(pvu_pkg::CfgClampMode, {noise[31:1], clamp});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic longint pick_gain();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 262143;
      default: return $urandom_range(0, 262143);
    endcase
  endfunction

  function automatic longint pick_word(longint a, longint b);
    longint          lo;
    longint          hi;
    longint          span;
    longint unsigned r;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case ($urandom_range(0, 7))
      0: return longint'($signed($urandom));
      1: begin
        case ($urandom_range(0, 3))
          0: return WMIN;
          1: return WMAX;
          2: return 0;
          default: return -1;
        endcase
      end
      default: begin
        span = hi - lo + 1;
        r = {$urandom, $urandom};
        return board.sat_word(lo - span / 4 + longint'(r % (span + span / 2)));
      end
    endcase
  endfunction

  function automatic longint pick_fraction(longint top);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  task automatic random_setting();
    longint centre;
    longint half;
    longint lo;
    longint hi;
    centre = $urandom_range(0, 33554431) - 64'sd16777216;
    half = $urandom_range(1, 4194304);
    case ($urandom_range(0, 9))
      0: begin lo = WMIN; hi = WMAX; end
      1: begin lo = centre; hi = centre; end
      2: begin lo = centre + half; hi = centre - half; end
      default: begin lo = centre - half; hi = centre + half; end
    endcase
    apply_setting(pick_gain(), pick_gain(), lo, hi, $urandom_range(0, 1));
  endtask

  task automatic random_phase(int count, bit last_part);
    longint q;
    bit     gaps_on;
    gaps_on = 1'b0;
    q = (board.pos_high > board.pos_low) ? (board.pos_high - board.pos_low) / 4 : Q;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) gaps_on = !last_part && ($urandom_range(0, 2) != 0);
      send_item(make_item(pick_word(-q, q),
                          pick_word(board.pos_low, board.pos_high),
                          pick_word(board.pos_low, board.pos_high),
                          pick_word(board.pos_low, board.pos_high),
                          pick_fraction(131071), pick_fraction(65535),
                          pick_fraction(65535)),
                gaps_on);
    end
  endtask

  initial begin
    longint b;
    board = new();
    b = pvu_pkg::BoundInt * Q;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    settings_used = 1;

    directed(0, 0, 0, 0, 0, 0, 0);
    directed(Q, 0, 0, 0, Q, 0, 0);
    directed(WMAX, 0, 0, 0, 131071, 0, 0);
    directed(WMIN, 0, 0, 0, 131071, 0, 0);
    directed(0, b, b, b, Q, 65535, 65535);
    directed(0, -b, -b, -b, Q, 65535, 65535);
    directed(1, b, b, b, Q, 0, 0);
    directed(WMAX, WMIN, WMAX, WMAX, 131071, 65535, 65535);
    directed(WMIN, WMAX, WMIN, WMIN, 131071, 65535, 65535);
    directed(-1, Q, Q + 3, Q - 7, 1, 12345, 54321);
    settle();

    apply_setting(0, 262143, -b, b, 1'b0);
    directed(-3 * Q, -b, -b, -b, Q, 0, 0);
    directed(5 * Q, b, b, b, Q, 0, 0);
    directed(-2 * b, -b, -b, -b, Q, 0, 0);
    directed(2 * b, b, b, b, Q, 0, 0);
    directed(WMAX, WMAX, 0, 0, 131071, 65535, 65535);
    directed(0, 0, WMAX, WMIN, 0, 65535, 65535);
    settle();

    apply_setting(262143, 0, WMIN, WMAX, 1'b0);
    directed(WMIN, WMIN, 0, 0, 131071, 65535, 0);
    directed(WMAX, WMAX, 0, 0, 131071, 0, 65535);
    settle();

    apply_setting(Q, Q, 0, 0, 1'b0);
    directed(0, 5, 5, 5, Q, 0, 0);
    directed(0, -5, -5, -5, Q, 0, 0);
    directed(0, 0, 0, 0, Q, 0, 0);
    settle();

    apply_setting(Q, Q, b, -b, 1'b1);
    directed(0, 0, 0, 0, Q, 0, 0);
    directed(0, 30 * Q, 30 * Q, 30 * Q, Q, 0, 0);
    settle();

    apply_setting(Q, Q, b, -b, 1'b0);
    directed(0, 0, 0, 0, Q, 0, 0);
    directed(0, 30 * Q, 30 * Q, 30 * Q, Q, 0, 0);
    settle();

    for (int k = 0; k < 6; k++) begin
      random_setting();
      random_phase(80, k == 5);
      settle();
    end

    $display("Checked %0d updates over %0d settings, %0d at a bound, %0d wrapped.",
             board.checked, settings_used, board.corrected, board.wrapped);
    $display("%0d mismatches, %0d results still outstanding.",
             board.mismatches, board.expected_updates.size());
    if (board.mismatches == 0 && board.expected_updates.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
